FILE: sv/aging_priority_thread_scheduler_macros.svh
// ----------------------------------------------------------------------------
// aging priority thread scheduler assertion macros
// concurrent check helpers used by the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef AGING_PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`define AGING_PRIORITY_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define APS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, disabled while reset is asserted
`define APS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: sv/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// shared types and constants of the aging priority thread scheduler
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int DEF_THREAD_SLOTS = 8;
    localparam int DEF_TICK_BITS    = 16;
    localparam int PRIO_W           = 8;
    localparam int BASE_W           = 7;
    localparam int OUT_SLOT_W       = 3;

    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic [BASE_W-1:0]        base_t;

    localparam prio_t PRIO_MIN   = prio_t'(-128);
    localparam base_t SLOT0_PRIO = base_t'(2);

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_CREATE  = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_SLEEP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // result of the shared compare and aging unit
    typedef struct packed {
        logic  better;
        prio_t aged;
    } age_res_t;

endpackage

FILE: sv/aps_age_unit.sv
// ----------------------------------------------------------------------------
// aps_age_unit
// shared slot compare and saturating aging step
// ----------------------------------------------------------------------------
module aps_age_unit (
    input  aps_pkg::prio_t    prio,
    input  aps_pkg::prio_t    best_prio,
    input  logic              have_best,
    output aps_pkg::age_res_t res
);
    import aps_pkg::*;

    // strict less-than keeps the lowest index on ties
    assign res.better = !have_best || (prio < best_prio);
    assign res.aged   = (prio == PRIO_MIN) ? prio : prio_t'(prio - prio_t'(1));

endmodule

FILE: sv/aging_priority_thread_scheduler.sv
// ----------------------------------------------------------------------------
// aging_priority_thread_scheduler
// thread slot scheduler with priority aging, one slot handled per cycle
// ----------------------------------------------------------------------------
// One request is taken at a time. A schedule tick or a create walks the slot
// file through a single compare and aging unit, one slot per clock: a tick
// passes through acceptance, one scan step per slot, a commit step that
// restores the winner's base priority, and the result load. A create stops
// at the first free slot. Release and sleep go from acceptance straight to
// the result load. The result sits in an output register, so the next
// request is accepted while an earlier result still waits for m_ready; a
// result that finds that register still full holds the block in its load
// state until m_ready. Reset restores slot 0 as the only thread in use, at
// priority 2, and makes it current.
// ----------------------------------------------------------------------------
`include "aging_priority_thread_scheduler_macros.svh"

module aging_priority_thread_scheduler #(
    parameter int THREAD_SLOTS = aps_pkg::DEF_THREAD_SLOTS,
    parameter int TICK_BITS    = aps_pkg::DEF_TICK_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [6:0]  s_level,
    input  logic [2:0]  s_slot_id,
    input  logic [15:0] s_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_current_slot_out,
    output logic [2:0]  m_created_slot,
    output logic        m_ok,
    output logic        m_idle
);
    import aps_pkg::*;

    localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(THREAD_SLOTS - 1);

    // slot file
    logic                 in_use_reg [THREAD_SLOTS];
    logic [TICK_BITS-1:0] sleep_reg  [THREAD_SLOTS];
    prio_t                wprio_reg  [THREAD_SLOTS];
    base_t                base_reg   [THREAD_SLOTS];
    logic [SLOT_W-1:0]    current_slot_reg;

    // sequencer and request context
    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg;
    func_t             func_reg;
    base_t             level_reg;

    // running winner of the tick scan
    logic              found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    prio_t             best_prio_reg;
    base_t             best_base_reg;

    // pending result fields
    logic [OUT_SLOT_W-1:0] res_created_reg;
    logic                  res_ok_reg;
    logic                  res_idle_reg;

    // output register
    logic                  m_valid_reg;
    logic [OUT_SLOT_W-1:0] m_current_slot_out_reg;
    logic [OUT_SLOT_W-1:0] m_created_slot_reg;
    logic                  m_ok_reg;
    logic                  m_idle_reg;

    // control decode
    logic     accept;
    logic     load_out;
    logic     scan_last;
    logic     cur_in_use;
    logic     cur_asleep;
    logic     cur_ready;
    logic     free_hit;
    age_res_t age_res;

    // the one compare and aging unit, fed from the slot under the scan index
    aps_age_unit u_age (
        .prio      (wprio_reg[idx_reg]),
        .best_prio (best_prio_reg),
        .have_best (found_reg),
        .res       (age_res)
    );

    assign cur_in_use = in_use_reg[idx_reg];
    assign cur_asleep = (sleep_reg[idx_reg] != '0);
    assign cur_ready  = cur_in_use && !cur_asleep;
    assign free_hit   = (func_reg == FUNC_CREATE) && !cur_in_use;
    assign scan_last  = (idx_reg == LAST_IDX);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (func_t'(s_func))
                        FUNC_TICK, FUNC_CREATE:    state_next = ST_SCAN;
                        FUNC_RELEASE, FUNC_SLEEP:  state_next = ST_DONE;
                        default:                   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (func_reg == FUNC_TICK) begin
                    if (scan_last) state_next = ST_COMMIT;
                end else if (free_hit || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready  = 1'b1;
            ST_SCAN:   s_ready  = 1'b0;
            ST_COMMIT: s_ready  = 1'b0;
            ST_DONE:   load_out = !m_valid_reg || m_ready;
            default:   s_ready  = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            func_reg         <= FUNC_TICK;
            level_reg        <= '0;
            found_reg        <= 1'b0;
            best_idx_reg     <= '0;
            best_prio_reg    <= '0;
            best_base_reg    <= '0;
            res_created_reg  <= '0;
            res_ok_reg       <= 1'b0;
            res_idle_reg     <= 1'b0;
            current_slot_reg <= '0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                in_use_reg[i] <= (i == 0);
                sleep_reg[i]  <= '0;
                wprio_reg[i]  <= (i == 0) ? prio_t'({1'b0, SLOT0_PRIO}) : '0;
                base_reg[i]   <= (i == 0) ? SLOT0_PRIO : '0;
            end
        end else begin
            state_reg <= state_next;

            // request acceptance, release and sleep complete right here
            if (accept) begin
                idx_reg         <= '0;
                func_reg        <= func_t'(s_func);
                level_reg       <= s_level;
                found_reg       <= 1'b0;
                res_created_reg <= '0;
                res_ok_reg      <= 1'b0;
                res_idle_reg    <= 1'b0;
                case (func_t'(s_func))
                    FUNC_RELEASE: begin
                        if (32'(s_slot_id) < 32'(THREAD_SLOTS)) begin
                            in_use_reg[SLOT_W'(s_slot_id)] <= 1'b0;
                        end
                    end
                    FUNC_SLEEP: begin
                        sleep_reg[current_slot_reg] <= TICK_BITS'(s_ticks);
                    end
                    default: ;
                endcase
            end

            // one slot per cycle through the shared unit
            if (state_reg == ST_SCAN) begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (func_reg == FUNC_TICK) begin
                    if (cur_in_use && cur_asleep) begin
                        sleep_reg[idx_reg] <= sleep_reg[idx_reg] - TICK_BITS'(1);
                    end
                    // age every ready slot, the winner is restored at commit
                    if (cur_ready) begin
                        wprio_reg[idx_reg] <= age_res.aged;
                        if (age_res.better) begin
                            found_reg     <= 1'b1;
                            best_idx_reg  <= idx_reg;
                            best_prio_reg <= wprio_reg[idx_reg];
                            best_base_reg <= base_reg[idx_reg];
                        end
                    end
                end else if (free_hit) begin
                    in_use_reg[idx_reg] <= 1'b1;
                    sleep_reg[idx_reg]  <= '0;
                    base_reg[idx_reg]   <= level_reg;
                    wprio_reg[idx_reg]  <= prio_t'({1'b0, level_reg});
                    res_created_reg     <= OUT_SLOT_W'(32'(idx_reg));
                    res_ok_reg          <= 1'b1;
                end
            end

            // winner takes its base priority and becomes current
            if (state_reg == ST_COMMIT) begin
                if (found_reg) begin
                    wprio_reg[best_idx_reg] <= prio_t'({1'b0, best_base_reg});
                    current_slot_reg        <= best_idx_reg;
                    res_ok_reg              <= 1'b1;
                end else begin
                    res_idle_reg <= 1'b1;
                end
            end

            // output register, refilled only when free or being drained
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_current_slot_out_reg <= OUT_SLOT_W'(32'(current_slot_reg));
            m_created_slot_reg     <= res_created_reg;
            m_ok_reg               <= res_ok_reg;
            m_idle_reg             <= res_idle_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_current_slot_out = m_current_slot_out_reg;
    assign m_created_slot     = m_created_slot_reg;
    assign m_ok               = m_ok_reg;
    assign m_idle             = m_idle_reg;

    // a request keeps the block busy in the cycle after its acceptance
    `APS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready)
    // a result never reports both a selection and idle
    `APS_ASSERT_NOW(a_ok_idle_excl, aclk, aresetn, m_valid, !(m_ok && m_idle))
    // a nonzero created slot only comes with a successful create
    `APS_ASSERT_NOW(a_created_ok, aclk, aresetn, m_valid && (m_created_slot != '0), m_ok)
    // the scan index stays inside the slot file
    `APS_ASSERT_NOW(a_idx_range, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= LAST_IDX)

endmodule
